>>> rtl/pamp_pkg.sv
// ----------------------------------------------------------------------------
// pamp_pkg: shared definitions of the palette attribute map painter
// Grid geometry, field widths, action codes, the decoded command carried
// from the front end to the back end, and the back end state encoding.
// ----------------------------------------------------------------------------
package pamp_pkg;

	// Grid geometry, in character cells.
	localparam int GRID_COLUMNS = 20;
	localparam int GRID_ROWS    = 18;

	// Field widths.
	localparam int COORD_W = 8;
	localparam int PAL_W   = 2;
	localparam int ACT_W   = 3;

	// Index widths into a row and into the row store.
	localparam int COL_W = (GRID_COLUMNS > 1) ? $clog2(GRID_COLUMNS) : 1;
	localparam int ROW_W = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;

	// Grid bounds as coordinates, for compares against 8-bit fields.
	localparam logic [COORD_W-1:0] COLS_COORD = COORD_W'(GRID_COLUMNS);
	localparam logic [COORD_W-1:0] ROWS_COORD = COORD_W'(GRID_ROWS);
	localparam logic [ROW_W-1:0]   ROW_LAST   = ROW_W'(GRID_ROWS - 1);

	// A line command only uses the low five bits of its index.
	localparam logic [COORD_W-1:0] LINE_INDEX_MASK = 8'h1F;

	// Command queue between the front and back ends.
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	// Action codes of the input beat.
	typedef enum logic [ACT_W-1:0] {
		ACT_BLOCK     = 3'd0,
		ACT_LINE      = 3'd1,
		ACT_DIVIDE    = 3'd2,
		ACT_CHR_START = 3'd3,
		ACT_CHR_PUT   = 3'd4,
		ACT_READ      = 3'd5
	} action_t;

	// What the back end has to do with a command.
	typedef enum logic [2:0] {
		CMD_BLOCK,
		CMD_LINE,
		CMD_DIVIDE,
		CMD_PUT,
		CMD_READ,
		CMD_NONE
	} cmd_kind_t;

	// Decoded command, with the cursor already advanced by the front end.
	typedef struct packed {
		cmd_kind_t            kind;
		logic                 fill_inside;
		logic                 fill_edge;
		logic                 fill_outside;
		logic [PAL_W-1:0]     pal_inside;
		logic [PAL_W-1:0]     pal_edge;
		logic [PAL_W-1:0]     pal_outside;
		logic                 horizontal;
		logic [COORD_W-1:0]   x_first;
		logic [COORD_W-1:0]   y_first;
		logic [COORD_W-1:0]   x_last;
		logic [COORD_W-1:0]   y_last;
		logic [COORD_W-1:0]   cursor_col;
		logic [COORD_W-1:0]   cursor_row;
	} cmd_t;

	// Queue occupancy seen by both ends.
	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	// One grid row: a palette number for each column.
	typedef logic [GRID_COLUMNS-1:0][PAL_W-1:0] row_t;

	// Back end sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN,
		ST_RESULT
	} state_t;

endpackage

>>> rtl/palette_attribute_map_painter.sv
// ----------------------------------------------------------------------------
// palette_attribute_map_painter: palette map of a 20 by 18 character grid
//
// Command beats arrive on the cmd channel (valid/ready); every command gives
// exactly one result beat on the res channel (valid/ready) with the cell
// palette of a read and the character cursor after the command.
// The front end decodes beats and runs the cursor; it takes a beat whenever
// the two-entry command queue has room, so it keeps accepting while the back
// end works or a result waits to be taken.
// The back end serves one command at a time. A block, line or divide sweeps
// all grid rows with one row read-modify-write per cycle: it takes the
// command, sweeps the 18 rows, drains the last write and loads the result.
// A chr put or read inside the grid sweeps only its own row; other commands
// go straight to loading the result. A new command is taken only after the
// last one has loaded its result.
// Reset clears the cursor, the queue and per-row valid bits, so the whole
// grid reads as zero at once without a clearing pass.
// When the receiver stalls, the result stays in the output register, the
// back end waits, the queue fills and cmd_ready falls.
// ----------------------------------------------------------------------------
module palette_attribute_map_painter import pamp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  logic [ACT_W-1:0]   action,
	input  logic               fill_inside,
	input  logic               fill_edge,
	input  logic               fill_outside,
	input  logic [PAL_W-1:0]   pal_inside,
	input  logic [PAL_W-1:0]   pal_edge,
	input  logic [PAL_W-1:0]   pal_outside,
	input  logic               horizontal,
	input  logic [COORD_W-1:0] x_first,
	input  logic [COORD_W-1:0] y_first,
	input  logic [COORD_W-1:0] x_last,
	input  logic [COORD_W-1:0] y_last,
	output logic               res_valid,
	input  logic               res_ready,
	output logic [PAL_W-1:0]   cell_palette,
	output logic [COORD_W-1:0] cursor_col,
	output logic [COORD_W-1:0] cursor_row
);

	q_status_t q_status;
	logic      push, q_pop;
	cmd_t      push_cmd, q_cmd;

	pamp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.action       (action),
		.fill_inside  (fill_inside),
		.fill_edge    (fill_edge),
		.fill_outside (fill_outside),
		.pal_inside   (pal_inside),
		.pal_edge     (pal_edge),
		.pal_outside  (pal_outside),
		.horizontal   (horizontal),
		.x_first      (x_first),
		.y_first      (y_first),
		.x_last       (x_last),
		.y_last       (y_last),
		.q_status     (q_status),
		.push         (push),
		.push_cmd     (push_cmd)
	);

	pamp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (q_pop),
		.pop_cmd  (q_cmd),
		.q_status (q_status)
	);

	pamp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_status     (q_status),
		.q_cmd        (q_cmd),
		.q_pop        (q_pop),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.cell_palette (cell_palette),
		.cursor_col   (cursor_col),
		.cursor_row   (cursor_row)
	);

`ifndef SYNTHESIS
	// The back end only takes a command that is queued.
	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_status.empty)
		else $error("command taken from an empty queue");

	// A beat accepted without a pop leaves the queue occupied.
	a_push_occupies: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !q_pop) |=> !q_status.empty)
		else $error("accepted beat lost from the queue");

	// The back end never takes two commands back to back.
	a_no_double_pop: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> !q_pop)
		else $error("back end took two commands in a row");
`endif

endmodule

>>> rtl/pamp_front.sv
// ----------------------------------------------------------------------------
// pamp_front: command decode and character cursor
// Accepts command beats, resolves the block border rule and the line index,
// runs the character cursor, and pushes decoded commands into the queue.
// ----------------------------------------------------------------------------
module pamp_front import pamp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  logic [ACT_W-1:0]   action,
	input  logic               fill_inside,
	input  logic               fill_edge,
	input  logic               fill_outside,
	input  logic [PAL_W-1:0]   pal_inside,
	input  logic [PAL_W-1:0]   pal_edge,
	input  logic [PAL_W-1:0]   pal_outside,
	input  logic               horizontal,
	input  logic [COORD_W-1:0] x_first,
	input  logic [COORD_W-1:0] y_first,
	input  logic [COORD_W-1:0] x_last,
	input  logic [COORD_W-1:0] y_last,
	input  q_status_t          q_status,
	output logic               push,
	output cmd_t               push_cmd
);

	logic [COORD_W-1:0] cursor_x_q, cursor_y_q, start_x_q, start_y_q;
	logic               advance_vertical_q;
	logic [COORD_W-1:0] nxt_cursor_x, nxt_cursor_y, nxt_start_x, nxt_start_y;
	logic               nxt_advance_vertical;

	// A beat is taken whenever the queue has room.
	assign cmd_ready = !q_status.full;
	assign push      = cmd_valid && cmd_ready;

	// Decode the beat and work out the cursor after it.
	always_comb begin
		push_cmd              = '0;
		push_cmd.kind         = CMD_NONE;
		push_cmd.fill_inside  = fill_inside;
		push_cmd.fill_edge    = fill_edge;
		push_cmd.fill_outside = fill_outside;
		push_cmd.pal_inside   = pal_inside;
		push_cmd.pal_edge     = pal_edge;
		push_cmd.pal_outside  = pal_outside;
		push_cmd.horizontal   = horizontal;
		push_cmd.x_first      = x_first;
		push_cmd.y_first      = y_first;
		push_cmd.x_last       = x_last;
		push_cmd.y_last       = y_last;
		nxt_cursor_x          = cursor_x_q;
		nxt_cursor_y          = cursor_y_q;
		nxt_start_x           = start_x_q;
		nxt_start_y           = start_y_q;
		nxt_advance_vertical  = advance_vertical_q;
		case (action)
			ACT_BLOCK: begin
				push_cmd.kind = CMD_BLOCK;
				// With the border off and only one of inside or outside enabled, the border follows it.
				if (fill_outside && !fill_inside && !fill_edge) begin
					push_cmd.fill_edge = 1'b1;
					push_cmd.pal_edge  = pal_outside;
				end
				if (!fill_outside && fill_inside && !fill_edge) begin
					push_cmd.fill_edge = 1'b1;
					push_cmd.pal_edge  = pal_inside;
				end
			end
			ACT_LINE: begin
				push_cmd.kind    = CMD_LINE;
				push_cmd.x_first = x_first & LINE_INDEX_MASK;
			end
			ACT_DIVIDE: begin
				push_cmd.kind = CMD_DIVIDE;
			end
			ACT_CHR_START: begin
				nxt_cursor_x         = x_first;
				nxt_cursor_y         = y_first;
				nxt_start_x          = x_first;
				nxt_start_y          = y_first;
				nxt_advance_vertical = horizontal;
			end
			ACT_CHR_PUT: begin
				push_cmd.kind    = CMD_PUT;
				push_cmd.x_first = cursor_x_q;
				push_cmd.y_first = cursor_y_q;
				// Step the cursor, wrapping at the grid edge back to the start.
				if (advance_vertical_q) begin
					nxt_cursor_y = cursor_y_q + 8'd1;
					if (nxt_cursor_y == ROWS_COORD) begin
						nxt_cursor_y = start_y_q;
						nxt_cursor_x = cursor_x_q + 8'd1;
					end
				end else begin
					nxt_cursor_x = cursor_x_q + 8'd1;
					if (nxt_cursor_x == COLS_COORD) begin
						nxt_cursor_x = start_x_q;
						nxt_cursor_y = cursor_y_q + 8'd1;
					end
				end
			end
			ACT_READ: begin
				push_cmd.kind = CMD_READ;
			end
			default: begin
				push_cmd.kind = CMD_NONE;
			end
		endcase
		push_cmd.cursor_col = nxt_cursor_x;
		push_cmd.cursor_row = nxt_cursor_y;
	end

	// Cursor registers move on every accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q         <= '0;
			cursor_y_q         <= '0;
			start_x_q          <= '0;
			start_y_q          <= '0;
			advance_vertical_q <= 1'b0;
		end else if (push) begin
			cursor_x_q         <= nxt_cursor_x;
			cursor_y_q         <= nxt_cursor_y;
			start_x_q          <= nxt_start_x;
			start_y_q          <= nxt_start_y;
			advance_vertical_q <= nxt_advance_vertical;
		end
	end

endmodule

>>> rtl/pamp_queue.sv
// ----------------------------------------------------------------------------
// pamp_queue: command queue
// A short first-in first-out store of decoded commands that lets the front
// end keep accepting beats while the back end works.
// ----------------------------------------------------------------------------
module pamp_queue import pamp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cmd_t      push_cmd,
	input  logic      pop,
	output cmd_t      pop_cmd,
	output q_status_t q_status
);

	cmd_t                entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_CW-1:0] count_q;

	assign pop_cmd        = entry_q[rd_ptr_q];
	assign q_status.empty = (count_q == '0);
	assign q_status.full  = (count_q == QUEUE_CW'(QUEUE_DEPTH));

	// Entry storage needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers wrap at the queue depth; the count tracks occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 :
					wr_ptr_q + QUEUE_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 :
					rd_ptr_q + QUEUE_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QUEUE_CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QUEUE_CW'(1);
			end
		end
	end

endmodule

>>> rtl/pamp_back.sv
// ----------------------------------------------------------------------------
// pamp_back: grid store and row sequencer
// Takes one command at a time from the queue, sweeps the rows it touches with
// a read-modify-write of one row per cycle, and holds the result beat.
// ----------------------------------------------------------------------------
module pamp_back import pamp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  q_status_t          q_status,
	input  cmd_t               q_cmd,
	output logic               q_pop,
	output logic               res_valid,
	input  logic               res_ready,
	output logic [PAL_W-1:0]   cell_palette,
	output logic [COORD_W-1:0] cursor_col,
	output logic [COORD_W-1:0] cursor_row
);

	// Palette of one cell after a command, given its old palette.
	function automatic logic [PAL_W-1:0] paint_cell(input cmd_t c,
			input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
			input logic [PAL_W-1:0] old);
		logic               in_rect;
		logic               on_border;
		logic [COORD_W-1:0] k;
		logic [PAL_W-1:0]   res;
		res       = old;
		in_rect   = (x > c.x_first) && (x < c.x_last) && (y > c.y_first) && (y < c.y_last);
		on_border = ((x == c.x_first || x == c.x_last) && y >= c.y_first && y <= c.y_last) ||
			((y == c.y_first || y == c.y_last) && x >= c.x_first && x <= c.x_last);
		k         = c.horizontal ? y : x;
		case (c.kind)
			CMD_BLOCK: begin
				if (in_rect) begin
					if (c.fill_inside) res = c.pal_inside;
				end else if (on_border) begin
					if (c.fill_edge) res = c.pal_edge;
				end else if (c.fill_outside) begin
					res = c.pal_outside;
				end
			end
			CMD_LINE: begin
				if (k == c.x_first) res = c.pal_inside;
			end
			CMD_DIVIDE: begin
				if (k < c.x_first) res = c.pal_inside;
				else if (k == c.x_first) res = c.pal_edge;
				else res = c.pal_outside;
			end
			CMD_PUT: begin
				if (x == c.x_first) res = c.pal_inside;
			end
			default: begin
				res = old;
			end
		endcase
		return res;
	endfunction

	state_t             state_q, state_nxt;
	cmd_t               cmd_q;
	logic [ROW_W-1:0]   row_q, row_last_q;
	logic [PAL_W-1:0]   cell_q;
	logic               needs_grid;
	logic               rd_en, load_out;

	row_t               grid_mem [GRID_ROWS];
	logic [GRID_ROWS-1:0] row_valid_q;
	logic               rd_valid_s1;
	logic [ROW_W-1:0]   rd_row_s1;
	row_t               rd_data_s1;
	logic               rd_row_valid_s1;
	row_t               old_row, new_row;

	logic               res_valid_q;
	logic [PAL_W-1:0]   cell_palette_q;
	logic [COORD_W-1:0] cursor_col_q, cursor_row_q;

	// Paints sweep the whole grid; a put or a read touches one in-grid row.
	always_comb begin
		case (q_cmd.kind)
			CMD_BLOCK, CMD_LINE, CMD_DIVIDE: needs_grid = 1'b1;
			CMD_PUT, CMD_READ: needs_grid = (q_cmd.x_first < COLS_COORD) &&
				(q_cmd.y_first < ROWS_COORD);
			default: needs_grid = 1'b0;
		endcase
	end

	// Sequencer next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (!q_status.empty) state_nxt = needs_grid ? ST_SWEEP : ST_RESULT;
			end
			ST_SWEEP: begin
				if (row_q == row_last_q) state_nxt = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_nxt = ST_RESULT;
			end
			ST_RESULT: begin
				if (load_out) state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		q_pop    = 1'b0;
		rd_en    = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE:   q_pop = !q_status.empty;
			ST_SWEEP:  rd_en = 1'b1;
			ST_RESULT: load_out = !res_valid_q || res_ready;
			default:   q_pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Command register and row counter.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd;
			cell_q <= '0;
			if (q_cmd.kind == CMD_PUT || q_cmd.kind == CMD_READ) begin
				row_q      <= q_cmd.y_first[ROW_W-1:0];
				row_last_q <= q_cmd.y_first[ROW_W-1:0];
			end else begin
				row_q      <= '0;
				row_last_q <= ROW_LAST;
			end
		end else begin
			if (rd_en) row_q <= row_q + ROW_W'(1);
			if (rd_valid_s1 && cmd_q.kind == CMD_READ) begin
				cell_q <= old_row[cmd_q.x_first[COL_W-1:0]];
			end
		end
	end

	// Row read, registered.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1      <= grid_mem[row_q];
			rd_row_valid_s1 <= row_valid_q[row_q];
			rd_row_s1       <= row_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_en;
		end
	end

	// A row never written since reset reads as all zero.
	assign old_row = rd_row_valid_s1 ? rd_data_s1 : '0;

	// Merge the command into the row just read.
	always_comb begin
		for (int c = 0; c < GRID_COLUMNS; c++) begin
			new_row[c] = paint_cell(cmd_q, COORD_W'(c), COORD_W'(rd_row_s1), old_row[c]);
		end
	end

	// Row write back.
	always_ff @(posedge clk) begin
		if (rd_valid_s1) begin
			grid_mem[rd_row_s1] <= new_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (rd_valid_s1) begin
			row_valid_q[rd_row_s1] <= 1'b1;
		end
	end

	// Result register, held while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_out) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			cell_palette_q <= cell_q;
			cursor_col_q   <= cmd_q.cursor_col;
			cursor_row_q   <= cmd_q.cursor_row;
		end
	end

	assign res_valid    = res_valid_q;
	assign cell_palette = cell_palette_q;
	assign cursor_col   = cursor_col_q;
	assign cursor_row   = cursor_row_q;

endmodule
